/* src/bps_pkg.sv */
// Package for the beeper pattern sequencer.
// Holds the request codes and the field widths shared by the RTL.
// It has no dependencies.
package bps_pkg;

  localparam int unsigned PhaseW = 8;
  localparam int unsigned UnitsW = 8;
  localparam int unsigned TimerW = 14;
  localparam int unsigned HeartW = 4;

  typedef enum logic [1:0] {
    REQ_FAST_TICK = 2'd0,
    REQ_START     = 2'd1,
    REQ_SET_BLINK = 2'd2,
    REQ_SLOW_TICK = 2'd3
  } req_e;

endpackage

/* src/beep_pattern_sequencer.sv */
// Top level of the beeper pattern sequencer.
// Depends on bps_pkg for the request codes and the field widths.
//
// The block accepts one item per clock cycle while the output is not stalled, and
// returns one result per item. An input register catches the item, and it is then
// applied to the pattern state, which also forms the result register, once that
// register is free or its result is taken. Results leave in order. While a
// result waits, the input register can still take one item, and the input then
// stalls until the waiting result is taken. No clearing pass is needed after
// reset.
module beep_pattern_sequencer
  import bps_pkg::*;
#(
  parameter int unsigned TICK_SCALE = 50,
  parameter int unsigned HEART_HOLD = 15
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        req_type_i,
  input  logic [PhaseW-1:0] phase_count_i,
  input  logic [UnitsW-1:0] on_units_i,
  input  logic [UnitsW-1:0] off_units_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              beeper_drive_o,
  output logic              key_lamp_o,
  output logic              heart_stop_o,
  output logic              busy_res_o
);

  logic              sound_enable_q;

  logic              s1_valid_q;
  req_e              s1_req_q;
  logic [PhaseW-1:0] s1_count_q;
  logic [UnitsW-1:0] s1_on_q;
  logic [UnitsW-1:0] s1_off_q;

  logic              out_valid_q;
  logic              adv_s2;
  logic              take_s1;

  logic              active_q, active_d;
  logic              blink_q, blink_d;
  logic              key_lamp_q, key_lamp_d;
  logic              heart_stop_q, heart_stop_d;
  logic [HeartW-1:0] heart_cnt_q, heart_cnt_d;
  logic [PhaseW-1:0] phase_idx_q, phase_idx_d;
  logic [TimerW-1:0] timer_q, timer_d;
  logic [TimerW-1:0] on_len_q, on_len_d;
  logic [TimerW-1:0] off_len_q, off_len_d;
  logic [PhaseW-1:0] total_q, total_d;
  logic              beeper_q, beeper_d;

  logic [TimerW-1:0] on_prod;
  logic [TimerW-1:0] off_prod;
  logic [TimerW-1:0] cur_len;

  assign adv_s2     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign take_s1    = in_valid_i && !in_stall_o;
  assign in_stall_o = s1_valid_q && !adv_s2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sound_enable_q <= 1'b0;
    end else if (cfg_we_i) begin
      sound_enable_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (take_s1) begin
      s1_valid_q <= 1'b1;
    end else if (adv_s2) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_s1) begin
      s1_req_q   <= req_e'(req_type_i);
      s1_count_q <= phase_count_i;
      s1_on_q    <= on_units_i;
      s1_off_q   <= off_units_i;
    end
  end

  assign on_prod  = TimerW'(s1_on_q) * TimerW'(TICK_SCALE);
  assign off_prod = TimerW'(s1_off_q) * TimerW'(TICK_SCALE);
  assign cur_len  = phase_idx_q[0] ? off_len_q : on_len_q;

  always_comb begin
    active_d     = active_q;
    blink_d      = blink_q;
    key_lamp_d   = key_lamp_q;
    heart_stop_d = heart_stop_q;
    heart_cnt_d  = heart_cnt_q;
    phase_idx_d  = phase_idx_q;
    timer_d      = timer_q;
    on_len_d     = on_len_q;
    off_len_d    = off_len_q;
    total_d      = total_q;
    beeper_d     = beeper_q;
    case (s1_req_q)
      REQ_FAST_TICK: begin
        if (!active_q) begin
          beeper_d = 1'b0;
        end else if (phase_idx_q < total_q) begin
          if (timer_q == '0) begin
            if (phase_idx_q[0]) begin
              beeper_d = 1'b0;
              if (blink_q) begin
                key_lamp_d = 1'b0;
              end
            end else begin
              if (sound_enable_q) begin
                beeper_d = 1'b1;
              end
              if (blink_q) begin
                key_lamp_d = 1'b1;
              end
              heart_stop_d = 1'b1;
              heart_cnt_d  = '0;
            end
          end
          if (timer_q >= cur_len) begin
            timer_d     = '0;
            phase_idx_d = phase_idx_q + PhaseW'(1);
          end else begin
            timer_d = timer_q + TimerW'(1);
          end
        end else begin
          blink_d     = 1'b0;
          key_lamp_d  = 1'b1;
          phase_idx_d = '0;
          timer_d     = '0;
          active_d    = 1'b0;
          beeper_d    = 1'b0;
        end
      end
      REQ_START: begin
        total_d   = s1_count_q;
        on_len_d  = on_prod;
        off_len_d = off_prod;
        active_d  = 1'b1;
      end
      REQ_SET_BLINK: begin
        blink_d = 1'b1;
      end
      REQ_SLOW_TICK: begin
        if (heart_cnt_q < HeartW'(HEART_HOLD)) begin
          heart_cnt_d = heart_cnt_q + HeartW'(1);
        end else begin
          heart_stop_d = 1'b0;
        end
      end
      default: begin
        blink_d = blink_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      active_q     <= 1'b0;
      blink_q      <= 1'b0;
      key_lamp_q   <= 1'b1;
      heart_stop_q <= 1'b0;
      heart_cnt_q  <= '0;
      phase_idx_q  <= '0;
      timer_q      <= '0;
      on_len_q     <= '0;
      off_len_q    <= '0;
      total_q      <= '0;
      beeper_q     <= 1'b0;
    end else begin
      if (adv_s2) begin
        out_valid_q  <= 1'b1;
        active_q     <= active_d;
        blink_q      <= blink_d;
        key_lamp_q   <= key_lamp_d;
        heart_stop_q <= heart_stop_d;
        heart_cnt_q  <= heart_cnt_d;
        phase_idx_q  <= phase_idx_d;
        timer_q      <= timer_d;
        on_len_q     <= on_len_d;
        off_len_q    <= off_len_d;
        total_q      <= total_d;
        beeper_q     <= beeper_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign beeper_drive_o = beeper_q;
  assign key_lamp_o     = key_lamp_q;
  assign heart_stop_o   = heart_stop_q;
  assign busy_res_o     = active_q;

`ifndef NO_ASSERTIONS
  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q)
    else $error("input stalled with an empty input register");

  a_start_sets_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_s2 && s1_req_q == REQ_START) |=> (busy_res_o && out_valid_o))
    else $error("start item did not mark the pattern busy");

  a_heart_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    heart_cnt_q <= HeartW'(HEART_HOLD))
    else $error("heart counter passed its hold count");

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !active_q |-> (timer_q == '0 && phase_idx_q == '0))
    else $error("phase state left over while no pattern runs");

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(active_q) && $stable(beeper_q))
    else $error("stalled result changed");
`endif

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for beep_pattern_sequencer: a directed request table, then random
// pattern sequences under several handshake idling mixes, checked against a local predictor
// or, for typed rows, the table's levels. Depends on bps_pkg and the sequencer RTL.
module tb_top;
  import bps_pkg::*;

  localparam int unsigned TickScale  = 50;
  localparam int unsigned HeartHold  = 15;
  localparam int unsigned StallLimit = 4000;
  localparam int unsigned NumRows    = 15;
  localparam int unsigned ItemsPerMode = 100;

  typedef struct packed {
    logic beep;
    logic key;
    logic heart;
    logic busy;
  } levels_t;

  typedef struct packed {
    req_e       req;
    logic [7:0] cnt;
    logic [7:0] on_u;
    logic [7:0] off_u;
    logic [7:0] reps;
    logic       typed;
    levels_t    want;
  } req_row_t;

  // The last column holds beeper, key lamp, heart stop and busy, in that order.
  req_row_t dir_rows [NumRows] = '{
    '{REQ_FAST_TICK, 8'd0,   8'd0,   8'd0,   8'd1, 1'b1, 4'b0100},
    '{REQ_SLOW_TICK, 8'd0,   8'd0,   8'd0,   8'd1, 1'b1, 4'b0100},
    '{REQ_SET_BLINK, 8'd0,   8'd0,   8'd0,   8'd1, 1'b1, 4'b0100},
    '{REQ_START,     8'd0,   8'd0,   8'd0,   8'd1, 1'b1, 4'b0101},
    '{REQ_FAST_TICK, 8'd0,   8'd0,   8'd0,   8'd1, 1'b1, 4'b0100},
    '{REQ_SET_BLINK, 8'd0,   8'd0,   8'd0,   8'd1, 1'b1, 4'b0100},
    '{REQ_START,     8'd2,   8'd0,   8'd0,   8'd1, 1'b1, 4'b0101},
    '{REQ_FAST_TICK, 8'd0,   8'd0,   8'd0,   8'd3, 1'b0, 4'b0000},
    '{REQ_START,     8'd255, 8'd255, 8'd255, 8'd1, 1'b0, 4'b0000},
    '{REQ_FAST_TICK, 8'd0,   8'd0,   8'd0,   8'd2, 1'b0, 4'b0000},
    '{REQ_START,     8'd0,   8'd1,   8'd0,   8'd1, 1'b0, 4'b0000},
    '{REQ_FAST_TICK, 8'd0,   8'd0,   8'd0,   8'd1, 1'b1, 4'b0110},
    '{REQ_START,     8'd1,   8'd0,   8'd255, 8'd1, 1'b0, 4'b0000},
    '{REQ_FAST_TICK, 8'd0,   8'd0,   8'd0,   8'd2, 1'b0, 4'b0000},
    '{REQ_SLOW_TICK, 8'd0,   8'd0,   8'd0,   8'd3, 1'b0, 4'b0000}
  };

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              cfg_we_i      = 1'b0;
  logic              cfg_wdata_i   = 1'b0;
  logic              in_valid_i    = 1'b0;
  logic              in_stall_o;
  logic [1:0]        req_type_i    = REQ_FAST_TICK;
  logic [PhaseW-1:0] phase_count_i = '0;
  logic [UnitsW-1:0] on_units_i    = '0;
  logic [UnitsW-1:0] off_units_i   = '0;
  logic              out_valid_o;
  logic              out_stall_i   = 1'b0;
  logic              beeper_drive_o;
  logic              key_lamp_o;
  logic              heart_stop_o;
  logic              busy_res_o;

  logic              sound_en;
  logic              run_on;
  logic              blink_on;
  logic              key_lit;
  logic              heart_flag;
  logic              beep_lvl;
  logic [HeartW-1:0] heart_cnt;
  logic [PhaseW-1:0] step_idx;
  logic [PhaseW-1:0] step_total;
  logic [TimerW-1:0] step_tmr;
  logic [TimerW-1:0] on_len;
  logic [TimerW-1:0] off_len;

  levels_t     level_q [$];
  int unsigned mismatches  = 0;
  int unsigned items_sent  = 0;
  int unsigned gap_pct     = 0;
  int unsigned stall_pct   = 0;
  int unsigned idle_cycles = 0;

  beep_pattern_sequencer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .req_type_i    (req_type_i),
    .phase_count_i (phase_count_i),
    .on_units_i    (on_units_i),
    .off_units_i   (off_units_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .beeper_drive_o(beeper_drive_o),
    .key_lamp_o    (key_lamp_o),
    .heart_stop_o  (heart_stop_o),
    .busy_res_o    (busy_res_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic levels_t apply_request(req_e req, logic [7:0] cnt, logic [7:0] on_u,
                                            logic [7:0] off_u);
    logic [TimerW-1:0] len;
    case (req)
      REQ_FAST_TICK: begin
        if (!run_on) begin
          beep_lvl = 1'b0;
        end else if (step_idx < step_total) begin
          if (step_idx[0]) begin
            if (step_tmr == '0) begin
              beep_lvl = 1'b0;
              if (blink_on) key_lit = 1'b0;
            end
            len = off_len;
          end else begin
            if (step_tmr == '0) begin
              if (sound_en) beep_lvl = 1'b1;
              if (blink_on) key_lit = 1'b1;
              heart_flag = 1'b1;
              heart_cnt  = '0;
            end
            len = on_len;
          end
          if (step_tmr >= len) begin
            step_tmr = '0;
            step_idx = step_idx + PhaseW'(1);
          end else begin
            step_tmr = step_tmr + TimerW'(1);
          end
        end else begin
          blink_on = 1'b0;
          key_lit  = 1'b1;
          step_idx = '0;
          step_tmr = '0;
          run_on   = 1'b0;
          beep_lvl = 1'b0;
        end
      end
      REQ_START: begin
        step_total = cnt;
        on_len     = TimerW'(on_u * TickScale);
        off_len    = TimerW'(off_u * TickScale);
        run_on     = 1'b1;
      end
      REQ_SET_BLINK: begin
        blink_on = 1'b1;
      end
      default: begin
        if (heart_cnt < HeartW'(HeartHold)) begin
          heart_cnt = heart_cnt + HeartW'(1);
        end else begin
          heart_flag = 1'b0;
        end
      end
    endcase
    return '{beep_lvl, key_lit, heart_flag, run_on};
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < 40) $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic push_item(input req_e req, input logic [7:0] cnt, input logic [7:0] on_u,
                           input logic [7:0] off_u, input logic typed, input levels_t want);
    levels_t pred;
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    req_type_i    <= req;
    phase_count_i <= cnt;
    on_units_i    <= on_u;
    off_units_i   <= off_u;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pred = apply_request(req, cnt, on_u, off_u);
    level_q.push_back(typed ? want : pred);
    items_sent++;
  endtask

  task automatic write_sound(input logic value);
    in_valid_i <= 1'b0;
    while (level_q.size() != 0) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sound_en = value;
  endtask

  function automatic logic [7:0] pick_units();
    return ($urandom_range(99) < 85) ? 8'd0 : 8'd1;
  endfunction

  always @(posedge clk_i) begin
    levels_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (level_q.size() == 0) begin
        report_mismatch("result arrived with no item outstanding");
      end else begin
        want = level_q.pop_front();
        if (beeper_drive_o !== want.beep)
          report_mismatch($sformatf("beeper_drive got %b want %b", beeper_drive_o, want.beep));
        if (key_lamp_o !== want.key)
          report_mismatch($sformatf("key_lamp got %b want %b", key_lamp_o, want.key));
        if (heart_stop_o !== want.heart)
          report_mismatch($sformatf("heart_stop got %b want %b", heart_stop_o, want.heart));
        if (busy_res_o !== want.busy)
          report_mismatch($sformatf("busy_res got %b want %b", busy_res_o, want.busy));
      end
    end
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles = 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("tb_top NOT OK");
      $finish;
    end else begin
      idle_cycles++;
    end
  end

  initial begin
    int unsigned mode;
    int unsigned stop_at;
    int unsigned pick;
    sound_en   = 1'b0;
    run_on     = 1'b0;
    blink_on   = 1'b0;
    key_lit    = 1'b1;
    heart_flag = 1'b0;
    beep_lvl   = 1'b0;
    heart_cnt  = '0;
    step_idx   = '0;
    step_total = '0;
    step_tmr   = '0;
    on_len     = '0;
    off_len    = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_sound(1'b1);
    foreach (dir_rows[i]) begin
      repeat (dir_rows[i].reps) begin
        push_item(dir_rows[i].req, dir_rows[i].cnt, dir_rows[i].on_u, dir_rows[i].off_u,
                  dir_rows[i].typed, dir_rows[i].want);
      end
    end

    for (mode = 0; mode < 4; mode++) begin
      write_sound(mode == 2 ? 1'($urandom_range(1)) : 1'(mode % 2));
      case (mode)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 62; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 62; end
        default: begin gap_pct = 6; stall_pct = 6; end
      endcase
      stop_at = items_sent + ItemsPerMode;
      while (items_sent < stop_at) begin
        pick = $urandom_range(99);
        if (pick < 65) begin
          if ($urandom_range(1) == 1) push_item(REQ_SET_BLINK, 8'($urandom), 8'($urandom),
                                                8'($urandom), 1'b0, '0);
          push_item(REQ_START, 8'($urandom_range(4)), pick_units(), pick_units(), 1'b0, '0);
          while (run_on) begin
            if ($urandom_range(99) < 3) break;
            if ($urandom_range(99) < 15) begin
              push_item(REQ_SLOW_TICK, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0, '0);
            end else begin
              push_item(REQ_FAST_TICK, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0, '0);
            end
          end
        end else if (pick < 75) begin
          repeat ($urandom_range(14, 18)) begin
            push_item(REQ_SLOW_TICK, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0, '0);
          end
        end else begin
          repeat ($urandom_range(1, 4)) begin
            push_item(req_e'($urandom_range(3)), 8'($urandom), 8'($urandom), 8'($urandom),
                      1'b0, '0);
          end
        end
      end
    end

    in_valid_i <= 1'b0;
    while (level_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/bps_pkg.sv
src/beep_pattern_sequencer.sv
tb/tb_top.sv
